@@ hdl/slr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slr_pkg: shared types and constants of the SLR parse engine
// Item kinds, action codes, result events, parse status, sequencer states and
// the command word that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package slr_pkg;

   // First nonterminal symbol code; goto columns are offset from it.
   localparam logic [5:0] NT_BASE = 6'd29;

   typedef logic [5:0] sym_type;
   typedef logic [4:0] tok_type;
   typedef logic [8:0] depth_type;

   typedef enum logic [2:0] {
      KIND_ACTION  = 3'd0,
      KIND_GOTO    = 3'd1,
      KIND_PROD    = 3'd2,
      KIND_TOKEN   = 3'd3,
      KIND_RESTART = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ACT_ERROR  = 2'd0,
      ACT_SHIFT  = 2'd1,
      ACT_REDUCE = 2'd2,
      ACT_ACCEPT = 2'd3
   } act_type;

   typedef enum logic [2:0] {
      EV_SHIFT  = 3'd0,
      EV_REDUCE = 3'd1,
      EV_ACCEPT = 3'd2,
      EV_SYNTAX = 3'd3,
      EV_STACK  = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      ST_RUN      = 2'd0,
      ST_ACCEPTED = 2'd1,
      ST_SYNTAX   = 2'd2,
      ST_STACK    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      B_CLEAR = 3'd0,
      B_IDLE  = 3'd1,
      B_ACT   = 3'd2,
      B_DEC   = 3'd3,
      B_PROD  = 3'd4,
      B_BASE  = 3'd5,
      B_GRD   = 3'd6,
      B_GOTO  = 3'd7
   } back_state_type;

   typedef struct packed {
      kind_type kind;
      sym_type  row;
      sym_type  column;
      act_type  action_kind;
      sym_type  value;
      tok_type  token_code;
   } cmd_type;

   // Event that repeats a halted outcome.
   function automatic event_type status_event(status_type s);
      event_type ev;
      case (s)
         ST_ACCEPTED: ev = EV_ACCEPT;
         ST_SYNTAX:   ev = EV_SYNTAX;
         default:     ev = EV_STACK;
      endcase
      return ev;
   endfunction

endpackage
`default_nettype wire

@@ hdl/slr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slr_front: input classification
// Accepts items, drops unknown kinds and out-of-range table writes, and
// forwards the rest as commands to the queue.
// ----------------------------------------------------------------------------
module slr_front #(
   parameter int NUM_STATES       = 64,
   parameter int NUM_TERMINALS    = 32,
   parameter int NUM_NONTERMINALS = 16,
   parameter int NUM_PRODUCTIONS  = 64
) (
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [2:0]       req_kind,
   input  wire logic [5:0]       req_row,
   input  wire logic [5:0]       req_column,
   input  wire logic [1:0]       req_action_kind,
   input  wire logic [5:0]       req_value,
   input  wire logic [4:0]       req_token_code,
   input  wire logic             q_full,
   input  wire logic             clearing,
   output logic                  q_push,
   output slr_pkg::cmd_type      q_cmd
);

   logic    keep;
   logic    row_state_ok;
   logic    [5:0] nt_index;

   assign req_stall    = q_full | clearing;
   assign row_state_ok = 32'(req_row) < NUM_STATES;
   assign nt_index     = req_column - slr_pkg::NT_BASE;

   always_comb begin
      case (req_kind)
         slr_pkg::KIND_ACTION: begin
            keep = row_state_ok && (32'(req_column) < NUM_TERMINALS);
         end
         slr_pkg::KIND_GOTO: begin
            keep = row_state_ok && (req_column >= slr_pkg::NT_BASE)
                   && (32'(nt_index) < NUM_NONTERMINALS);
         end
         slr_pkg::KIND_PROD: begin
            keep = 32'(req_row) < NUM_PRODUCTIONS;
         end
         slr_pkg::KIND_TOKEN,
         slr_pkg::KIND_RESTART: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign q_push = req_valid & ~req_stall & keep;

   always_comb begin
      q_cmd.kind        = slr_pkg::kind_type'(req_kind);
      q_cmd.row         = req_row;
      q_cmd.column      = req_column;
      q_cmd.action_kind = slr_pkg::act_type'(req_action_kind);
      q_cmd.value       = req_value;
      q_cmd.token_code  = req_token_code;
   end

endmodule
`default_nettype wire

@@ hdl/slr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slr_queue: two-entry command queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module slr_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire slr_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output slr_pkg::cmd_type      head_cmd
);

   slr_pkg::cmd_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ hdl/slr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slr_back: table memories, state stack and parse sequencer
// Executes table writes and restarts, runs the shift/reduce loop for tokens
// and drives the result register.
// ----------------------------------------------------------------------------
module slr_back #(
   parameter int STACK_DEPTH      = 512,
   parameter int NUM_STATES       = 64,
   parameter int NUM_TERMINALS    = 32,
   parameter int NUM_NONTERMINALS = 16,
   parameter int NUM_PRODUCTIONS  = 64,
   parameter int MAX_REDUCE_RUN   = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire slr_pkg::cmd_type q_cmd,
   output logic                  q_pop,
   output logic                  clearing,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [2:0]            rsp_event_res,
   output logic [5:0]            rsp_number,
   output logic [8:0]            rsp_stack_depth,
   output logic                  rsp_last
);

   localparam int TOP_W   = $clog2(STACK_DEPTH);
   localparam int CMP_W   = TOP_W + 6;
   localparam int ACT_N   = NUM_STATES * NUM_TERMINALS;
   localparam int ACT_AW  = $clog2(ACT_N);
   localparam int GOTO_N  = NUM_STATES * NUM_NONTERMINALS;
   localparam int GOTO_AW = $clog2(GOTO_N);
   localparam int PROD_AW = $clog2(NUM_PRODUCTIONS);
   localparam int CLR_A   = (ACT_N > GOTO_N) ? ACT_N : GOTO_N;
   localparam int CLR_N   = (CLR_A > NUM_PRODUCTIONS) ? CLR_A : NUM_PRODUCTIONS;
   localparam int CLR_W   = $clog2(CLR_N);
   localparam int RUN_W   = $clog2(MAX_REDUCE_RUN + 1);

   // Memories
   logic [7:0]  act_mem_ff  [ACT_N];
   logic [5:0]  goto_mem_ff [GOTO_N];
   logic [11:0] prod_mem_ff [NUM_PRODUCTIONS];
   logic [5:0]  stk_mem_ff  [STACK_DEPTH];

   logic [7:0]  act_q_ff;
   logic        act_zero_ff;
   logic [5:0]  goto_q_ff;
   logic        goto_zero_ff;
   logic [11:0] prod_q_ff;
   logic        prod_zero_ff;
   logic [5:0]  stk_q_ff;

   // Sequencer registers
   slr_pkg::back_state_type state_ff, state_in;
   slr_pkg::status_type     status_ff, status_in;
   logic [TOP_W-1:0]        top_ff, top_in;
   logic [5:0]              top_state_ff, top_state_in;
   logic [4:0]              tok_ff, tok_in;
   logic [RUN_W-1:0]        run_ff, run_in;
   logic [5:0]              tgt_ff, tgt_in;
   logic [5:0]              left_ff, left_in;
   logic [TOP_W-1:0]        base_ff, base_in;
   logic [CLR_W-1:0]        clr_ff, clr_in;

   // Result register
   logic                    out_valid_ff;
   slr_pkg::event_type      out_event_ff;
   logic [5:0]              out_number_ff;
   slr_pkg::depth_type      out_depth_ff;
   logic                    out_last_ff;

   // Memory ports
   logic               act_we, goto_we, prod_we, stk_we;
   logic [ACT_AW-1:0]  act_wa, act_ra;
   logic [GOTO_AW-1:0] goto_wa, goto_ra;
   logic [PROD_AW-1:0] prod_wa, prod_ra;
   logic [TOP_W-1:0]   stk_wa;
   logic [7:0]         act_wd;
   logic [5:0]         goto_wd, stk_wd;
   logic [11:0]        prod_wd;
   logic               act_rd_ok, goto_rd_ok, prod_rd_ok;

   // Decoded data
   logic [7:0]           act_data;
   slr_pkg::act_type     act_kind;
   logic [5:0]           act_tgt;
   logic [11:0]          prod_data;
   logic [5:0]           prod_left;
   logic [5:0]           prod_len;
   logic [TOP_W-1:0]     red_base;
   logic [5:0]           base_state;
   logic [5:0]           goto_nt;
   logic [5:0]           goto_state;
   logic [5:0]           cmd_nt;
   logic                 top_full;

   // Emission
   logic                 emit_ok;
   logic                 emit;
   slr_pkg::event_type   emit_event;
   logic [5:0]           emit_num;
   logic [TOP_W-1:0]     emit_depth;
   logic                 emit_last;

   assign clearing = (state_ff == slr_pkg::B_CLEAR);
   assign emit_ok  = ~out_valid_ff | ~rsp_stall;

   assign act_data = act_zero_ff ? 8'd0 : act_q_ff;
   assign act_kind = slr_pkg::act_type'(act_data[7:6]);
   assign act_tgt  = act_data[5:0];

   assign prod_data = prod_zero_ff ? 12'd0 : prod_q_ff;
   assign prod_left = prod_data[11:6];
   assign prod_len  = prod_data[5:0];
   assign red_base  = top_ff - TOP_W'(prod_len);

   // The bottom entry of the stack is never written and is read as state 0.
   assign base_state = (base_ff == '0) ? 6'd0 : stk_q_ff;
   assign goto_nt    = left_ff - slr_pkg::NT_BASE;
   assign goto_state = goto_zero_ff ? 6'd0 : goto_q_ff;
   assign cmd_nt     = q_cmd.column - slr_pkg::NT_BASE;
   assign top_full   = 32'(top_ff) >= STACK_DEPTH - 1;

   // Read addresses follow the sequencer registers, so data holds while stalled.
   assign act_rd_ok  = (32'(top_state_ff) < NUM_STATES) && (32'(tok_ff) < NUM_TERMINALS);
   assign act_ra     = ACT_AW'(32'(top_state_ff) * NUM_TERMINALS + 32'(tok_ff));
   assign prod_rd_ok = 32'(act_tgt) < NUM_PRODUCTIONS;
   assign prod_ra    = PROD_AW'(act_tgt);
   assign goto_rd_ok = (32'(base_state) < NUM_STATES) && (left_ff >= slr_pkg::NT_BASE)
                       && (32'(goto_nt) < NUM_NONTERMINALS);
   assign goto_ra    = GOTO_AW'(32'(base_state) * NUM_NONTERMINALS + 32'(goto_nt));

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      top_in       = top_ff;
      top_state_in = top_state_ff;
      tok_in       = tok_ff;
      run_in       = run_ff;
      tgt_in       = tgt_ff;
      left_in      = left_ff;
      base_in      = base_ff;
      clr_in       = clr_ff;
      q_pop        = 1'b0;
      act_we       = 1'b0;
      act_wa       = ACT_AW'(32'(q_cmd.row) * NUM_TERMINALS + 32'(q_cmd.column));
      act_wd       = {q_cmd.action_kind, q_cmd.value};
      goto_we      = 1'b0;
      goto_wa      = GOTO_AW'(32'(q_cmd.row) * NUM_NONTERMINALS + 32'(cmd_nt));
      goto_wd      = q_cmd.value;
      prod_we      = 1'b0;
      prod_wa      = PROD_AW'(q_cmd.row);
      prod_wd      = {q_cmd.column, q_cmd.value};
      stk_we       = 1'b0;
      stk_wa       = top_ff + 1'b1;
      stk_wd       = act_tgt;
      emit         = 1'b0;
      emit_event   = slr_pkg::EV_SHIFT;
      emit_num     = 6'd0;
      emit_depth   = top_ff;
      emit_last    = 1'b1;

      case (state_ff)
         slr_pkg::B_CLEAR: begin
            act_we  = 32'(clr_ff) < ACT_N;
            act_wa  = ACT_AW'(clr_ff);
            act_wd  = 8'd0;
            goto_we = 32'(clr_ff) < GOTO_N;
            goto_wa = GOTO_AW'(clr_ff);
            goto_wd = 6'd0;
            prod_we = 32'(clr_ff) < NUM_PRODUCTIONS;
            prod_wa = PROD_AW'(clr_ff);
            prod_wd = 12'd0;
            if (32'(clr_ff) == CLR_N - 1) begin
               state_in = slr_pkg::B_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         slr_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.kind)
                  slr_pkg::KIND_ACTION: begin
                     act_we = 1'b1;
                  end
                  slr_pkg::KIND_GOTO: begin
                     goto_we = 1'b1;
                  end
                  slr_pkg::KIND_PROD: begin
                     prod_we = 1'b1;
                  end
                  slr_pkg::KIND_TOKEN: begin
                     tok_in   = q_cmd.token_code;
                     run_in   = '0;
                     state_in = slr_pkg::B_ACT;
                  end
                  slr_pkg::KIND_RESTART: begin
                     top_in       = '0;
                     top_state_in = 6'd0;
                     status_in    = slr_pkg::ST_RUN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         slr_pkg::B_ACT: begin
            if (status_ff != slr_pkg::ST_RUN) begin
               if (emit_ok) begin
                  emit       = 1'b1;
                  emit_event = slr_pkg::status_event(status_ff);
                  state_in   = slr_pkg::B_IDLE;
               end
            end else begin
               state_in = slr_pkg::B_DEC;
            end
         end
         slr_pkg::B_DEC: begin
            case (act_kind)
               slr_pkg::ACT_SHIFT: begin
                  if (emit_ok) begin
                     emit     = 1'b1;
                     state_in = slr_pkg::B_IDLE;
                     if (top_full) begin
                        emit_event = slr_pkg::EV_STACK;
                        status_in  = slr_pkg::ST_STACK;
                     end else begin
                        stk_we       = 1'b1;
                        top_in       = top_ff + 1'b1;
                        top_state_in = act_tgt;
                        emit_event   = slr_pkg::EV_SHIFT;
                        emit_num     = act_tgt;
                        emit_depth   = top_ff + 1'b1;
                     end
                  end
               end
               slr_pkg::ACT_REDUCE: begin
                  if (32'(run_ff) >= MAX_REDUCE_RUN) begin
                     if (emit_ok) begin
                        emit       = 1'b1;
                        emit_event = slr_pkg::EV_STACK;
                        status_in  = slr_pkg::ST_STACK;
                        state_in   = slr_pkg::B_IDLE;
                     end
                  end else begin
                     tgt_in   = act_tgt;
                     state_in = slr_pkg::B_PROD;
                  end
               end
               slr_pkg::ACT_ACCEPT: begin
                  if (emit_ok) begin
                     emit       = 1'b1;
                     emit_event = slr_pkg::EV_ACCEPT;
                     status_in  = slr_pkg::ST_ACCEPTED;
                     state_in   = slr_pkg::B_IDLE;
                  end
               end
               default: begin
                  if (emit_ok) begin
                     emit       = 1'b1;
                     emit_event = slr_pkg::EV_SYNTAX;
                     status_in  = slr_pkg::ST_SYNTAX;
                     state_in   = slr_pkg::B_IDLE;
                  end
               end
            endcase
         end
         slr_pkg::B_PROD: begin
            // Underflow, or a reduction that would push past the last entry.
            if ((CMP_W'(prod_len) > CMP_W'(top_ff))
                  || (32'(red_base) >= STACK_DEPTH - 1)) begin
               if (emit_ok) begin
                  emit       = 1'b1;
                  emit_event = slr_pkg::EV_STACK;
                  status_in  = slr_pkg::ST_STACK;
                  state_in   = slr_pkg::B_IDLE;
               end
            end else begin
               base_in  = red_base;
               left_in  = prod_left;
               state_in = slr_pkg::B_BASE;
            end
         end
         slr_pkg::B_BASE: begin
            state_in = slr_pkg::B_GRD;
         end
         slr_pkg::B_GRD: begin
            state_in = slr_pkg::B_GOTO;
         end
         slr_pkg::B_GOTO: begin
            if (emit_ok) begin
               emit         = 1'b1;
               emit_event   = slr_pkg::EV_REDUCE;
               emit_num     = tgt_ff;
               emit_depth   = base_ff + 1'b1;
               emit_last    = 1'b0;
               stk_we       = 1'b1;
               stk_wa       = base_ff + 1'b1;
               stk_wd       = goto_state;
               top_in       = base_ff + 1'b1;
               top_state_in = goto_state;
               run_in       = run_ff + 1'b1;
               state_in     = slr_pkg::B_ACT;
            end
         end
         default: begin
            state_in = slr_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slr_pkg::B_CLEAR;
         status_ff    <= slr_pkg::ST_RUN;
         top_ff       <= '0;
         top_state_ff <= 6'd0;
         run_ff       <= '0;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         top_ff       <= top_in;
         top_state_ff <= top_state_in;
         run_ff       <= run_in;
         clr_ff       <= clr_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      tgt_ff  <= tgt_in;
      left_ff <= left_in;
      base_ff <= base_in;
      if (emit) begin
         out_event_ff  <= emit_event;
         out_number_ff <= emit_num;
         out_depth_ff  <= slr_pkg::depth_type'(emit_depth);
         out_last_ff   <= emit_last;
      end
   end

   // Table and stack memories: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem_ff[act_wa] <= act_wd;
      end
      act_q_ff    <= act_mem_ff[act_ra];
      act_zero_ff <= ~act_rd_ok;
   end

   always_ff @(posedge clock) begin
      if (goto_we) begin
         goto_mem_ff[goto_wa] <= goto_wd;
      end
      goto_q_ff    <= goto_mem_ff[goto_ra];
      goto_zero_ff <= ~goto_rd_ok;
   end

   always_ff @(posedge clock) begin
      if (prod_we) begin
         prod_mem_ff[prod_wa] <= prod_wd;
      end
      prod_q_ff    <= prod_mem_ff[prod_ra];
      prod_zero_ff <= ~prod_rd_ok;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem_ff[stk_wa] <= stk_wd;
      end
      stk_q_ff <= stk_mem_ff[base_ff];
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_res   = out_event_ff;
   assign rsp_number      = out_number_ff;
   assign rsp_stack_depth = out_depth_ff;
   assign rsp_last        = out_last_ff;

endmodule
`default_nettype wire

@@ hdl/slr_parse_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slr_parse_engine: table-driven SLR parse engine
// Loads ACTION, GOTO and production tables, then drives the LR shift/reduce
// loop for each token, reporting every reduction and the closing shift,
// accept or error.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Carries
//   req_      in         req_valid/req_stall  kind, row, column, action_kind,
//                                             value, token_code
//   rsp_      out        rsp_valid/rsp_stall  event_res, number, stack_depth,
//                                             last
//
// Timing: the front end takes an item per cycle while the two-entry queue has
// room and no clearing pass runs. The back end does a table write or restart as
// it pops it. A token goes through queue pop, ACTION read and decode to a shift,
// accept, syntax error or run-limit error, through pop and ACTION read alone
// when the parse is already halted, and on to the production read when a
// reduction fails its stack check; each reduction before the end adds ACTION
// read and decode, production read, stack read, GOTO read and push.
// Reset: after reset a clearing pass zeroes the three tables, one entry a
// cycle, stepping through as many entries as the largest table has (2048 at
// the default sizes); req_stall stays high while it runs.
// Stalls: results leave through a one-item output register; the sequencer
// waits in place while it holds an unaccepted result and has another to give.
//
module slr_parse_engine #(
   parameter int STACK_DEPTH      = 512,
   parameter int NUM_STATES       = 64,
   parameter int NUM_TERMINALS    = 32,
   parameter int NUM_NONTERMINALS = 16,
   parameter int NUM_PRODUCTIONS  = 64,
   parameter int MAX_REDUCE_RUN   = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_kind,
   input  wire logic [5:0] req_row,
   input  wire logic [5:0] req_column,
   input  wire logic [1:0] req_action_kind,
   input  wire logic [5:0] req_value,
   input  wire logic [4:0] req_token_code,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_event_res,
   output logic [5:0]      rsp_number,
   output logic [8:0]      rsp_stack_depth,
   output logic            rsp_last
);

   // Front end to queue
   logic             q_push;
   slr_pkg::cmd_type q_push_cmd;
   logic             q_full;

   // Queue to back end
   logic             q_pop;
   logic             q_valid;
   slr_pkg::cmd_type q_head;

   // The back end holds the input off while it clears the tables.
   logic             clearing;

   slr_front #(
      .NUM_STATES       (NUM_STATES),
      .NUM_TERMINALS    (NUM_TERMINALS),
      .NUM_NONTERMINALS (NUM_NONTERMINALS),
      .NUM_PRODUCTIONS  (NUM_PRODUCTIONS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_row         (req_row),
      .req_column      (req_column),
      .req_action_kind (req_action_kind),
      .req_value       (req_value),
      .req_token_code  (req_token_code),
      .q_full          (q_full),
      .clearing        (clearing),
      .q_push          (q_push),
      .q_cmd           (q_push_cmd)
   );

   slr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   // Table writes, restarts and tokens are carried out strictly in queue
   // order, so a later load never leaks into an earlier token's parse.
   slr_back #(
      .STACK_DEPTH      (STACK_DEPTH),
      .NUM_STATES       (NUM_STATES),
      .NUM_TERMINALS    (NUM_TERMINALS),
      .NUM_NONTERMINALS (NUM_NONTERMINALS),
      .NUM_PRODUCTIONS  (NUM_PRODUCTIONS),
      .MAX_REDUCE_RUN   (MAX_REDUCE_RUN)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_head),
      .q_pop           (q_pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_res   (rsp_event_res),
      .rsp_number      (rsp_number),
      .rsp_stack_depth (rsp_stack_depth),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire
